### rtl/ede_pkg.sv
// shared types and codes for the edit distance engine
`default_nettype none

package ede_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_ROW    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] character;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] distance;
    logic       error;
  } out_beat_t;

  typedef struct packed {
    logic append;
    logic start;
    logic row_done;
    logic err_set;
    logic finish;
    logic rd_en;
    logic calc_en;
  } ede_cmd_t;

endpackage

`default_nettype wire

### rtl/ede_dpath.sv
// datapath: string and row memories, lengths, cell update and result register
`default_nettype none

module ede_dpath import ede_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ede_cmd_t                          cmd_i,
  input  wire logic [7:0]                        character_i,
  input  wire logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_idx_i,
  input  wire logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] calc_idx_i,
  output logic [$clog2(MAX_LEN + 1)-1:0]         second_len_o,
  output logic [$clog2(MAX_LEN + 1)-1:0]         first_len_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output out_beat_t                              out_data_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [7:0]    ss_mem [MAX_LEN];
  logic [LW-1:0] cr_mem [MAX_LEN];

  logic [7:0]    ss_rd_q;
  logic [LW-1:0] cr_rd_q;
  logic [7:0]    ch_q;
  logic          init_q;
  logic [LW-1:0] diag_q;
  logic [LW-1:0] left_q;

  logic [LW-1:0] second_len_q, second_len_d;
  logic [LW-1:0] first_len_q, first_len_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_q;

  logic [LW-1:0] up;
  logic [LW-1:0] min_a;
  logic [LW-1:0] min_b;
  logic [LW-1:0] cost_new;
  logic [LW-1:0] dist_sel;
  logic [LW+7:0] dist_ext;

  // one cell of the row: left neighbor, cell above, diagonal
  always_comb begin
    up       = init_q ? (LW'(calc_idx_i) + LW'(1)) : cr_rd_q;
    min_a    = (left_q < up) ? left_q : up;
    min_b    = (min_a < diag_q) ? min_a : diag_q;
    cost_new = (ss_rd_q == ch_q) ? diag_q : (min_b + LW'(1));
  end

  always_comb begin
    dist_sel = (first_len_q == '0) ? second_len_q : left_q;
    dist_ext = (LW + 8)'(dist_sel);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      ss_mem[second_len_q[AW-1:0]] <= character_i;
    end
    if (cmd_i.calc_en) begin
      cr_mem[calc_idx_i] <= cost_new;
    end
    if (cmd_i.rd_en) begin
      ss_rd_q <= ss_mem[rd_idx_i];
      cr_rd_q <= cr_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ch_q   <= character_i;
      init_q <= (first_len_q == '0);
      diag_q <= first_len_q;
      left_q <= first_len_q + LW'(1);
    end else if (cmd_i.calc_en) begin
      diag_q <= up;
      left_q <= cost_new;
    end
    if (cmd_i.finish) begin
      out_q.distance <= dist_ext[7:0];
      out_q.error    <= err_q;
    end
  end

  always_comb begin
    second_len_d = second_len_q;
    first_len_d  = first_len_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.append) begin
      second_len_d = second_len_q + LW'(1);
    end
    if (cmd_i.row_done) begin
      first_len_d = first_len_q + LW'(1);
    end
    if (cmd_i.err_set) begin
      err_d = 1'b1;
    end
    if (cmd_i.finish) begin
      second_len_d = '0;
      first_len_d  = '0;
      err_d        = 1'b0;
      out_valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_len_q <= '0;
      first_len_q  <= '0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      second_len_q <= second_len_d;
      first_len_q  <= first_len_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign second_len_o = second_len_q;
  assign first_len_o  = first_len_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

endmodule

`default_nettype wire

### rtl/ede_ctrl.sv
// controller: op decode, input stall and the row walk sequencer
`default_nettype none

module ede_ctrl import ede_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire in_beat_t                          in_data_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]    second_len_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]    first_len_i,
  input  wire logic                              out_valid_i,
  output ede_cmd_t                               cmd_o,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_idx_o,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] calc_idx_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic          state_q, state_d;
  logic          rd_act_q, rd_act_d;
  logic          calc_act_q;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] calc_idx_q;
  logic [LW-1:0] last_len;
  logic [AW-1:0] last_idx;
  logic          accept;

  always_comb begin
    last_len = second_len_i - LW'(1);
    last_idx = last_len[AW-1:0];
  end

  assign in_stall_o = (state_q == ST_WALK) || (out_valid_i && in_data_i.op == OP_FINISH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_en   = rd_act_q;
    cmd_o.calc_en = calc_act_q;
    state_d       = state_q;
    rd_act_d      = rd_act_q;
    rd_idx_d      = rd_idx_q;

    if (rd_act_q) begin
      if (rd_idx_q == last_idx) begin
        rd_act_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + AW'(1);
      end
    end

    if (calc_act_q && calc_idx_q == last_idx) begin
      cmd_o.row_done = 1'b1;
      state_d        = ST_IDLE;
    end

    if (accept) begin
      case (in_data_i.op)
        OP_APPEND: begin
          if (first_len_i != '0 || second_len_i >= LW'(MAX_LEN)) begin
            cmd_o.err_set = 1'b1;
          end else begin
            cmd_o.append = 1'b1;
          end
        end
        OP_ROW: begin
          if (first_len_i >= LW'(MAX_LEN)) begin
            cmd_o.err_set = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (second_len_i == '0) begin
              cmd_o.row_done = 1'b1;
            end else begin
              state_d  = ST_WALK;
              rd_act_d = 1'b1;
              rd_idx_d = '0;
            end
          end
        end
        OP_FINISH: begin
          cmd_o.finish = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_act_q   <= 1'b0;
      calc_act_q <= 1'b0;
      rd_idx_q   <= '0;
      calc_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      rd_act_q   <= rd_act_d;
      calc_act_q <= rd_act_q;
      rd_idx_q   <= rd_idx_d;
      calc_idx_q <= rd_idx_q;
    end
  end

  assign rd_idx_o   = rd_idx_q;
  assign calc_idx_o = calc_idx_q;

  a_walk_needs_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> second_len_i != '0)
    else $error("row walk with empty second string");

  a_reads_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_act_q || calc_act_q) |-> state_q == ST_WALK)
    else $error("memory access outside row walk");

  a_calc_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_act_q |=> calc_act_q && calc_idx_q == $past(rd_idx_q))
    else $error("cell update lost its read");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.append, cmd_o.start, cmd_o.err_set, cmd_o.finish}))
    else $error("more than one action for one beat");

endmodule

`default_nettype wire

### rtl/edit_distance_engine_unit.sv
// top level of the levenshtein edit distance engine
//
// in channel: beats of {op, character} on in_valid_i / in_stall_o / in_data_i.
//   op append adds a byte to the second string,
//   op row runs one first-string byte over the stored cost row,
//   op finish loads the result register and clears the strings.
// out channel: one beat {distance, error} per finish on out_valid_o /
//   out_stall_i / out_data_o, shown the cycle after the finish beat.
// a row beat does one row memory read and one write per cell, with
//   the read data registered before the cell update; with an empty second
//   string it has no cells to walk.
// the distance is the low 8 bits of the count, error flags any byte
//   dropped for length or order since the last finish.
// while the receiver stalls, the result register holds and appends and
//   row beats keep flowing; a further finish beat waits.
// reset clears lengths, error flag and the output valid; the string and row
//   memories need no clearing, the first row beat seeds its row on the fly.
`default_nettype none

module edit_distance_engine_unit import ede_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  ede_cmd_t      cmd;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] calc_idx;
  logic [LW-1:0] second_len;
  logic [LW-1:0] first_len;
  logic          out_valid;

  ede_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .second_len_i (second_len),
    .first_len_i  (first_len),
    .out_valid_i  (out_valid),
    .cmd_o        (cmd),
    .rd_idx_o     (rd_idx),
    .calc_idx_o   (calc_idx)
  );

  ede_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .character_i  (in_data_i.character),
    .rd_idx_i     (rd_idx),
    .calc_idx_i   (calc_idx),
    .second_len_o (second_len),
    .first_len_o  (first_len),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  assign out_valid_o = out_valid;

endmodule

`default_nettype wire

### tb/edit_distance_engine_unit_test.sv
// testbench for edit_distance_engine_unit: random string pairs against a levenshtein row tracker
`timescale 1ns / 1ps

module edit_distance_engine_unit_test import ede_pkg::*;;

  localparam int MAX_LEN = 64;
  localparam logic [1:0] OP_VOID = 2'd3;
  localparam int RANDOM_ITEMS = 1150;

  typedef enum int {
    PAIR_PLAIN,
    PAIR_WIDE,
    PAIR_FULL,
    PAIR_LONG_SECOND,
    PAIR_LONG_FIRST,
    PAIR_ORDER
  } pair_kind_e;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_e;

  class levenshtein_tracker;
    logic [7:0]  second_str [MAX_LEN];
    int unsigned cost_row [MAX_LEN + 1];
    int unsigned second_len;
    int unsigned first_len;
    bit          dropped;
    out_beat_t   due_results [$];
    int unsigned mismatches;

    function void clear_pair();
      second_len = 0;
      first_len = 0;
      dropped = 1'b0;
    endfunction

    function new();
      clear_pair();
      mismatches = 0;
    endfunction

    function void take_request(in_beat_t b);
      int unsigned diag;
      int unsigned up;
      int unsigned left;
      int unsigned m;
      int unsigned cost;
      out_beat_t   res;
      case (b.op)
        OP_APPEND: begin
          if (first_len != 0 || second_len >= MAX_LEN) begin
            dropped = 1'b1;
          end else begin
            second_str[second_len] = b.character;
            second_len++;
          end
        end
        OP_ROW: begin
          if (first_len >= MAX_LEN) begin
            dropped = 1'b1;
          end else begin
            if (first_len == 0) begin
              for (int j = 0; j <= second_len; j++) cost_row[j] = j;
            end
            diag = cost_row[0];
            cost_row[0] = first_len + 1;
            for (int j = 1; j <= second_len; j++) begin
              up = cost_row[j];
              left = cost_row[j - 1];
              if (second_str[j - 1] == b.character) begin
                cost = diag;
              end else begin
                m = (left < up) ? left : up;
                if (diag < m) m = diag;
                cost = m + 1;
              end
              diag = up;
              cost_row[j] = cost;
            end
            first_len++;
          end
        end
        OP_FINISH: begin
          res.distance = (first_len == 0) ? 8'(second_len) : 8'(cost_row[second_len]);
          res.error = dropped;
          due_results.push_back(res);
          clear_pair();
        end
        default: begin
        end
      endcase
    endfunction

    function void match_result(out_beat_t r);
      out_beat_t e;
      if (due_results.size() == 0) begin
        $error("unexpected result beat: distance %0d error %0b", r.distance, r.error);
        mismatches++;
        return;
      end
      e = due_results.pop_front();
      if (r.distance !== e.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", e.distance, r.distance);
        mismatches++;
      end
      if (r.error !== e.error) begin
        $error("error mismatch: expected %0b, actual %0b", e.error, r.error);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  levenshtein_tracker tracker;
  int items_sent;
  int burst_left;

  edit_distance_engine_unit #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.take_request(in_data_i);
      if (out_valid_o && !out_stall_i) tracker.match_result(out_data_o);
    end
  end

  // receiver stall pattern, with a long hold to back the block up
  initial begin
    int seg;
    int span;
    int pick;
    stall_mode_e mode;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    seg = 0;
    forever begin
      pick = $urandom_range(0, 7);
      if (seg == 3 || pick == 7) mode = STALL_HOLD;
      else if (pick < 2) mode = STALL_NONE;
      else if (pick < 5) mode = STALL_LIGHT;
      else mode = STALL_HEAVY;
      span = (mode == STALL_HOLD) ? $urandom_range(300, 500) : $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 25);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 75);
          default:     out_stall_i <= 1'b1;
        endcase
      end
      seg++;
    end
  end

  task automatic push_beat(input logic [1:0] op, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= '{op: op, character: ch};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != OP_VOID) items_sent++;
  endtask

  function automatic logic [7:0] pick_char(bit narrow, logic [7:0] base);
    return narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic run_pair(input pair_kind_e kind);
    int len2;
    int len1;
    int cut;
    bit narrow;
    logic [7:0] base;
    narrow = $urandom_range(0, 1);
    base = 8'($urandom_range(0, 252));
    cut = -1;
    case (kind)
      PAIR_WIDE: begin
        len2 = $urandom_range(30, 64);
        len1 = $urandom_range(30, 64);
      end
      PAIR_FULL: begin
        len2 = MAX_LEN;
        len1 = MAX_LEN;
      end
      PAIR_LONG_SECOND: begin
        len2 = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
        len1 = $urandom_range(0, 4);
      end
      PAIR_LONG_FIRST: begin
        len2 = $urandom_range(0, 3);
        len1 = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
      end
      PAIR_ORDER: begin
        len2 = $urandom_range(0, 6);
        len1 = $urandom_range(1, 6);
        cut = $urandom_range(0, len1 - 1);
      end
      default: begin
        len2 = $urandom_range(0, 10);
        len1 = $urandom_range(0, 10);
      end
    endcase
    for (int i = 0; i < len2; i++) begin
      if ($urandom_range(0, 99) < 3) push_beat(OP_VOID, 8'($urandom_range(0, 255)));
      push_beat(OP_APPEND, pick_char(narrow, base));
    end
    for (int i = 0; i < len1; i++) begin
      if ($urandom_range(0, 99) < 3) push_beat(OP_VOID, 8'($urandom_range(0, 255)));
      push_beat(OP_ROW, pick_char(narrow, base));
      if (i == cut) push_beat(OP_APPEND, pick_char(narrow, base));
    end
    push_beat(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int pair_idx;
    int pick;
    pair_kind_e kind;
    tracker = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    items_sent = 0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // both strings empty
    push_beat(OP_FINISH, 8'hff);
    // empty first string
    push_beat(OP_APPEND, 8'h00);
    push_beat(OP_APPEND, 8'hff);
    push_beat(OP_FINISH, 8'h00);
    // empty second string
    push_beat(OP_ROW, 8'hff);
    push_beat(OP_ROW, 8'h00);
    push_beat(OP_FINISH, 8'h55);
    // swapped pair
    push_beat(OP_APPEND, 8'h41);
    push_beat(OP_APPEND, 8'h42);
    push_beat(OP_ROW, 8'h42);
    push_beat(OP_ROW, 8'h41);
    push_beat(OP_FINISH, 8'haa);
    // append after a row beat, plus an unused op
    push_beat(OP_APPEND, 8'h7f);
    push_beat(OP_ROW, 8'h80);
    push_beat(OP_APPEND, 8'h01);
    push_beat(OP_VOID, 8'hff);
    push_beat(OP_VOID, 8'h00);
    push_beat(OP_FINISH, 8'h0f);

    items_sent = 0;
    pair_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (pair_idx == 0) begin
        kind = PAIR_LONG_SECOND;
      end else if (pair_idx == 1) begin
        kind = PAIR_LONG_FIRST;
      end else if (pair_idx == 2) begin
        kind = PAIR_FULL;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) kind = PAIR_PLAIN;
        else if (pick < 78) kind = PAIR_WIDE;
        else if (pick < 85) kind = PAIR_LONG_SECOND;
        else if (pick < 91) kind = PAIR_LONG_FIRST;
        else kind = PAIR_ORDER;
      end
      run_pair(kind);
      pair_idx++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
